### design/cbr_pkg.sv
`default_nettype none

package cbr_pkg;

  // Controller / supervisor states
  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BUSOFF  = 2'd2,
    ST_RECOVER = 2'd3
  } sup_state_t;

  // Requested or completed actions (code 0 means nothing)
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_INIT  = 2'd1,
    ACT_START = 2'd2
  } act_t;

  localparam logic MODE_OBSERVE  = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  localparam logic REG_INITIAL_BACKOFF = 1'b0;
  localparam logic REG_MAX_BACKOFF     = 1'b1;

  localparam int BACKOFF_W = 31;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;

  localparam logic [BACKOFF_W-1:0] INITIAL_BACKOFF_RST = 31'd100;
  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST     = 31'd5000;

  typedef struct packed {
    logic              mode;
    logic [1:0]        driver_status;
    logic [1:0]        done_action;
    logic              succeeded;
    logic [TIME_W-1:0] now_time;
  } cbr_item_t;

  typedef struct packed {
    act_t              next_action;
    sup_state_t        tracked_state;
    logic [CNT_W-1:0]  bus_off_events;
    logic [CNT_W-1:0]  recoveries;
    logic [CNT_W-1:0]  initiate_attempts;
    logic [CNT_W-1:0]  initiate_failures;
    logic [CNT_W-1:0]  start_attempts;
    logic [CNT_W-1:0]  start_failures;
    logic [TIME_W-1:0] next_attempt_time;
  } cbr_result_t;

endpackage

`default_nettype wire

### design/cbr_item_if.sv
`default_nettype none

interface cbr_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  driver_status;
  logic [1:0]  done_action;
  logic        succeeded;
  logic [31:0] now_time;

  modport source (output valid, mode, driver_status, done_action, succeeded, now_time,
                  input ready);
  modport sink (input valid, mode, driver_status, done_action, succeeded, now_time,
                output ready);
endinterface

`default_nettype wire

### design/cbr_result_if.sv
`default_nettype none

interface cbr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  next_action;
  logic [1:0]  tracked_state;
  logic [31:0] bus_off_events;
  logic [31:0] recoveries;
  logic [31:0] initiate_attempts;
  logic [31:0] initiate_failures;
  logic [31:0] start_attempts;
  logic [31:0] start_failures;
  logic [31:0] next_attempt_time;

  modport source (output valid, next_action, tracked_state, bus_off_events, recoveries,
                  initiate_attempts, initiate_failures, start_attempts,
                  start_failures, next_attempt_time,
                  input ready);
  modport sink (input valid, next_action, tracked_state, bus_off_events, recoveries,
                initiate_attempts, initiate_failures, start_attempts,
                start_failures, next_attempt_time,
                output ready);
endinterface

`default_nettype wire

### design/cbr_core.sv
`default_nettype none

module cbr_core
  import cbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cbr_item_t            item,
  input  logic                 advance,
  input  logic [BACKOFF_W-1:0] initial_backoff,
  input  logic [BACKOFF_W-1:0] max_backoff,
  output cbr_result_t          res
);

  sup_state_t           state, state_next;
  logic [CNT_W-1:0]     bus_off_cnt, bus_off_cnt_next;
  logic [CNT_W-1:0]     recovery_cnt, recovery_cnt_next;
  logic [CNT_W-1:0]     init_att_cnt, init_att_cnt_next;
  logic [CNT_W-1:0]     init_fail_cnt, init_fail_cnt_next;
  logic [CNT_W-1:0]     start_att_cnt, start_att_cnt_next;
  logic [CNT_W-1:0]     start_fail_cnt, start_fail_cnt_next;
  logic [TIME_W-1:0]    attempt_time, attempt_time_next;
  logic [BACKOFF_W-1:0] cur_backoff, cur_backoff_next;

  act_t                 action;
  logic [TIME_W-1:0]    time_diff;
  logic                 time_ready;
  logic [BACKOFF_W:0]   doubled;
  logic [TIME_W-1:0]    retry_time;
  logic [BACKOFF_W-1:0] retry_backoff;

  // wrap-aware: ready when (now - attempt) is non-negative as a signed value
  assign time_diff  = item.now_time - attempt_time;
  assign time_ready = ~time_diff[TIME_W-1];

  assign doubled       = {cur_backoff, 1'b0};
  assign retry_time    = item.now_time + TIME_W'(cur_backoff);
  assign retry_backoff = (doubled < {1'b0, max_backoff}) ? doubled[BACKOFF_W-1:0]
                                                         : max_backoff;

  always_comb begin
    state_next          = state;
    bus_off_cnt_next    = bus_off_cnt;
    recovery_cnt_next   = recovery_cnt;
    init_att_cnt_next   = init_att_cnt;
    init_fail_cnt_next  = init_fail_cnt;
    start_att_cnt_next  = start_att_cnt;
    start_fail_cnt_next = start_fail_cnt;
    attempt_time_next   = attempt_time;
    cur_backoff_next    = cur_backoff;
    action              = ACT_NONE;

    if (item.mode == MODE_OBSERVE) begin
      unique case (sup_state_t'(item.driver_status))
        ST_RUNNING: begin
          state_next        = ST_RUNNING;
          attempt_time_next = '0;
          cur_backoff_next  = initial_backoff;
        end
        ST_BUSOFF: begin
          if (state != ST_RECOVER) begin
            if (state != ST_BUSOFF) begin
              // fresh entry: attempt time is now, so ready at once
              state_next        = ST_BUSOFF;
              bus_off_cnt_next  = bus_off_cnt + 1'b1;
              attempt_time_next = item.now_time;
              cur_backoff_next  = initial_backoff;
              action            = ACT_INIT;
            end else if (time_ready) begin
              action = ACT_INIT;
            end
          end
        end
        ST_RECOVER: begin
          state_next = ST_RECOVER;
        end
        ST_STOPPED: begin
          if (state == ST_RECOVER) begin
            if (time_ready) begin
              action = ACT_START;
            end
          end else begin
            state_next = ST_STOPPED;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (item.done_action)
        ACT_INIT: begin
          init_att_cnt_next = init_att_cnt + 1'b1;
          if (item.succeeded) begin
            state_next        = ST_RECOVER;
            attempt_time_next = '0;
            cur_backoff_next  = initial_backoff;
          end else begin
            init_fail_cnt_next = init_fail_cnt + 1'b1;
            state_next         = ST_BUSOFF;
            attempt_time_next  = retry_time;
            cur_backoff_next   = retry_backoff;
          end
        end
        ACT_START: begin
          start_att_cnt_next = start_att_cnt + 1'b1;
          if (item.succeeded) begin
            recovery_cnt_next = recovery_cnt + 1'b1;
            state_next        = ST_RUNNING;
            attempt_time_next = '0;
            cur_backoff_next  = initial_backoff;
          end else begin
            start_fail_cnt_next = start_fail_cnt + 1'b1;
            state_next          = ST_RECOVER;
            attempt_time_next   = retry_time;
            cur_backoff_next    = retry_backoff;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_STOPPED;
      bus_off_cnt    <= '0;
      recovery_cnt   <= '0;
      init_att_cnt   <= '0;
      init_fail_cnt  <= '0;
      start_att_cnt  <= '0;
      start_fail_cnt <= '0;
      attempt_time   <= '0;
      cur_backoff    <= INITIAL_BACKOFF_RST;
    end else if (advance) begin
      state          <= state_next;
      bus_off_cnt    <= bus_off_cnt_next;
      recovery_cnt   <= recovery_cnt_next;
      init_att_cnt   <= init_att_cnt_next;
      init_fail_cnt  <= init_fail_cnt_next;
      start_att_cnt  <= start_att_cnt_next;
      start_fail_cnt <= start_fail_cnt_next;
      attempt_time   <= attempt_time_next;
      cur_backoff    <= cur_backoff_next;
    end
  end

  always_comb begin
    res.next_action       = action;
    res.tracked_state     = state_next;
    res.bus_off_events    = bus_off_cnt_next;
    res.recoveries        = recovery_cnt_next;
    res.initiate_attempts = init_att_cnt_next;
    res.initiate_failures = init_fail_cnt_next;
    res.start_attempts    = start_att_cnt_next;
    res.start_failures    = start_fail_cnt_next;
    res.next_attempt_time = attempt_time_next;
  end

endmodule

`default_nettype wire

### design/can_bus_off_recovery_backoff_top.sv
`default_nettype none

// CAN bus-off recovery supervisor. Each request on "item" either observes the
// controller status at a millisecond timestamp (mode 0) or reports how a
// requested action ended (mode 1); each gives exactly one result on "result"
// with the next action (none / initiate / start), the tracked state, six
// wrapping event counters and the next allowed attempt time. A failed action
// schedules a retry at now plus the current backoff, which then doubles up to
// max_backoff. Timing: a request is registered at the input, then evaluated in one
// pass of the state-update logic as it moves to the output register; one request
// is taken every cycle while the result side keeps up. Both sides stall
// independently through the two registers. The user must write configuration
// (cfg_we / cfg_index / cfg_wdata) only while the block is idle; the block
// itself does not enforce this. A new initial_backoff takes effect at the next
// event that reloads the backoff.
module can_bus_off_recovery_backoff_top
  import cbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [BACKOFF_W-1:0] cfg_wdata,
  cbr_item_if.sink             item,
  cbr_result_if.source         result
);

  // configuration registers
  logic [BACKOFF_W-1:0] initial_backoff;
  logic [BACKOFF_W-1:0] max_backoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_backoff <= INITIAL_BACKOFF_RST;
      max_backoff     <= MAX_BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_BACKOFF: initial_backoff <= cfg_wdata;
        REG_MAX_BACKOFF:     max_backoff     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  logic        in_valid;
  cbr_item_t   in_item;
  logic        advance;
  cbr_result_t step_res;
  logic        out_valid;
  cbr_result_t out_res;

  // request moves from input register to result register
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      in_item.mode          <= item.mode;
      in_item.driver_status <= item.driver_status;
      in_item.done_action   <= item.done_action;
      in_item.succeeded     <= item.succeeded;
      in_item.now_time      <= item.now_time;
    end
  end

  // supervisor state and next-state logic
  cbr_core u_core (
    .clk             (clk),
    .rst             (rst),
    .item            (in_item),
    .advance         (advance),
    .initial_backoff (initial_backoff),
    .max_backoff     (max_backoff),
    .res             (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid             = out_valid;
  assign result.next_action       = out_res.next_action;
  assign result.tracked_state     = out_res.tracked_state;
  assign result.bus_off_events    = out_res.bus_off_events;
  assign result.recoveries        = out_res.recoveries;
  assign result.initiate_attempts = out_res.initiate_attempts;
  assign result.initiate_failures = out_res.initiate_failures;
  assign result.start_attempts    = out_res.start_attempts;
  assign result.start_failures    = out_res.start_failures;
  assign result.next_attempt_time = out_res.next_attempt_time;

  // an initiate request only comes out of the bus-off state
  a_init_in_busoff: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.next_action == ACT_INIT) |-> out_res.tracked_state == ST_BUSOFF)
    else $error("initiate requested outside bus off");

  // a start request only comes while recovering
  a_start_in_recover: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.next_action == ACT_START) |-> out_res.tracked_state == ST_RECOVER)
    else $error("start requested outside recovering");

  // a held request is not dropped while the result side stalls
  a_in_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("pending request lost");

  // a pending result is not overwritten while stalled
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_res)))
    else $error("pending result lost");

endmodule

`default_nettype wire
